@@ rtl/core/rkt_pkg.sv @@
// Shared types, widths and status codes for the reference-counted key table.
// No dependencies; used by rkt_table and refcounted_key_table.
package rkt_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W         = $clog2(TABLE_ENTRIES);
  localparam int SLOT_W        = 6;
  localparam int OWNER_W       = 8;
  localparam int KEY_W         = 32;
  localparam int REFS_W        = 16;
  localparam int STATUS_W      = 3;

  localparam logic [REFS_W-1:0] REFS_MAX = '1;

  // Opcodes
  localparam logic OP_GET = 1'b0;
  localparam logic OP_PUT = 1'b1;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_HIT       = 3'd0;
  localparam logic [STATUS_W-1:0] ST_CLAIMED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED  = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED     = 3'd4;
  localparam logic [STATUS_W-1:0] ST_ZERO      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_NULLOWNER = 3'd6;
  localparam logic [STATUS_W-1:0] ST_NOOP      = 3'd7;

  typedef struct packed {
    logic [OWNER_W-1:0] owner;
    logic [KEY_W-1:0]   key;
    logic [REFS_W-1:0]  refs;
  } entry_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    entry_t           data;
  } tbl_wr_t;

endpackage

@@ rtl/core/rkt_table.sv @@
// Entry storage: one-write, one-read memory with registered read data.
// Per-entry valid bits cleared by reset make unwritten entries read as zero.
// Depends on rkt_pkg.
module rkt_table (
  input  logic                    clk,
  input  logic                    rst,
  input  logic [rkt_pkg::IDX_W-1:0] rd_addr,
  output rkt_pkg::entry_t         rd_data,
  input  rkt_pkg::tbl_wr_t        wr
);

  rkt_pkg::entry_t                   mem [rkt_pkg::TABLE_ENTRIES];
  rkt_pkg::entry_t                   mem_q;
  logic [rkt_pkg::TABLE_ENTRIES-1:0] valid;
  logic                              valid_q;

  // Write and read the entry array
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    mem_q <= mem[rd_addr];
  end

  // Track which entries hold written data
  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      valid_q <= valid[rd_addr];
    end
  end

  // Unwritten entries read as the cleared value
  assign rd_data = valid_q ? mem_q : '0;

endmodule

@@ rtl/core/refcounted_key_table.sv @@
// Reference-counted key table: get looks up or claims an entry, put releases one.
// A get scans entries in order and stops at a hit; a claim or a full result needs the whole scan.
// Rejected requests (null owner, no slot, slot out of range) are answered straight from idle.
// Throughput: one transaction at a time, the next accepted as the result strobes; the
// linear scan through the single read port sets the get time. The receiver cannot stall.
// Reset: synchronous; all entries read as empty from the first cycle after reset.
module refcounted_key_table (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic                           opcode,
  input  logic [rkt_pkg::OWNER_W-1:0]    owner_id,
  input  logic [rkt_pkg::KEY_W-1:0]      key,
  input  logic                           slot_present,
  input  logic [rkt_pkg::SLOT_W-1:0]     slot,
  output logic                           done,
  output logic [rkt_pkg::STATUS_W-1:0]   status,
  output logic [rkt_pkg::SLOT_W-1:0]     result_slot,
  output logic [rkt_pkg::REFS_W-1:0]     count_after
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_HIT   = 3'd2;
  localparam logic [2:0] S_CLAIM = 3'd3;
  localparam logic [2:0] S_PUT   = 3'd4;

  localparam logic [rkt_pkg::IDX_W-1:0] IDX_LAST = rkt_pkg::IDX_W'(rkt_pkg::TABLE_ENTRIES - 1);

  logic [2:0]                      state;
  logic [rkt_pkg::IDX_W-1:0]       chk;
  logic [rkt_pkg::IDX_W-1:0]       work_idx;
  logic [rkt_pkg::IDX_W-1:0]       free_idx;
  logic                            free_found;
  logic [rkt_pkg::REFS_W-1:0]      work_refs;
  logic [rkt_pkg::OWNER_W-1:0]     req_owner;
  logic [rkt_pkg::KEY_W-1:0]       req_key;

  logic [rkt_pkg::IDX_W-1:0]       rd_addr;
  rkt_pkg::entry_t                 rd_data;
  rkt_pkg::tbl_wr_t                wr;

  logic                            match;
  logic                            free_hit;
  logic                            slot_oob;
  logic [rkt_pkg::REFS_W-1:0]      alu_base;
  logic [rkt_pkg::REFS_W-1:0]      alu_sum;

  rkt_table u_table (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  assign busy = (state != S_IDLE);

  // Compare the entry under scan against the request
  assign match    = (rd_data.owner == req_owner) && (rd_data.key == req_key);
  assign free_hit = !free_found && (rd_data.refs == '0);
  assign slot_oob = 32'(slot) >= 32'(rkt_pkg::TABLE_ENTRIES);

  // Shared count unit: saturating increment for a hit, decrement for a put
  assign alu_base = (state == S_HIT) ? work_refs : rd_data.refs;
  always_comb begin
    if (state == S_PUT) begin
      alu_sum = alu_base - rkt_pkg::REFS_W'(1);
    end else if (alu_base == rkt_pkg::REFS_MAX) begin
      alu_sum = alu_base;
    end else begin
      alu_sum = alu_base + rkt_pkg::REFS_W'(1);
    end
  end

  // Drive the memory read address and the write port
  always_comb begin
    rd_addr = '0;
    wr      = '0;
    unique case (state)
      S_IDLE: begin
        rd_addr = (opcode == rkt_pkg::OP_PUT) ? rkt_pkg::IDX_W'(slot) : '0;
      end
      S_SCAN: begin
        rd_addr = chk + rkt_pkg::IDX_W'(1);
      end
      S_HIT: begin
        wr.en         = 1'b1;
        wr.addr       = work_idx;
        wr.data.owner = req_owner;
        wr.data.key   = req_key;
        wr.data.refs  = alu_sum;
      end
      S_CLAIM: begin
        wr.en         = 1'b1;
        wr.addr       = free_idx;
        wr.data.owner = req_owner;
        wr.data.key   = req_key;
        wr.data.refs  = rkt_pkg::REFS_W'(1);
      end
      S_PUT: begin
        wr.addr = work_idx;
        if (rd_data.refs != '0) begin
          wr.en = 1'b1;
          if (alu_sum != '0) begin
            wr.data.owner = rd_data.owner;
            wr.data.key   = rd_data.key;
            wr.data.refs  = alu_sum;
          end
        end
      end
      default: begin
        rd_addr = '0;
      end
    endcase
  end

  // Sequence one transaction and register its result
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (opcode == rkt_pkg::OP_GET) begin
              if (owner_id == '0) begin
                done        <= 1'b1;
                status      <= rkt_pkg::ST_NULLOWNER;
                result_slot <= '0;
                count_after <= '0;
              end else begin
                req_owner  <= owner_id;
                req_key    <= key;
                chk        <= '0;
                free_found <= 1'b0;
                state      <= S_SCAN;
              end
            end else if (!slot_present) begin
              done        <= 1'b1;
              status      <= rkt_pkg::ST_NOOP;
              result_slot <= '0;
              count_after <= '0;
            end else if (slot_oob) begin
              done        <= 1'b1;
              status      <= rkt_pkg::ST_NOOP;
              result_slot <= slot;
              count_after <= '0;
            end else begin
              work_idx <= rkt_pkg::IDX_W'(slot);
              state    <= S_PUT;
            end
          end
        end
        S_SCAN: begin
          if (match) begin
            work_idx  <= chk;
            work_refs <= rd_data.refs;
            state     <= S_HIT;
          end else begin
            if (free_hit) begin
              free_found <= 1'b1;
              free_idx   <= chk;
            end
            if (chk == IDX_LAST) begin
              if (free_found || free_hit) begin
                state <= S_CLAIM;
              end else begin
                done        <= 1'b1;
                status      <= rkt_pkg::ST_FULL;
                result_slot <= '0;
                count_after <= '0;
                state       <= S_IDLE;
              end
            end else begin
              chk <= chk + rkt_pkg::IDX_W'(1);
            end
          end
        end
        S_HIT: begin
          done        <= 1'b1;
          status      <= rkt_pkg::ST_HIT;
          result_slot <= rkt_pkg::SLOT_W'(work_idx);
          count_after <= alu_sum;
          state       <= S_IDLE;
        end
        S_CLAIM: begin
          done        <= 1'b1;
          status      <= rkt_pkg::ST_CLAIMED;
          result_slot <= rkt_pkg::SLOT_W'(free_idx);
          count_after <= rkt_pkg::REFS_W'(1);
          state       <= S_IDLE;
        end
        S_PUT: begin
          done        <= 1'b1;
          result_slot <= rkt_pkg::SLOT_W'(work_idx);
          if (rd_data.refs == '0) begin
            status      <= rkt_pkg::ST_ZERO;
            count_after <= '0;
          end else if (alu_sum == '0) begin
            status      <= rkt_pkg::ST_FREED;
            count_after <= '0;
          end else begin
            status      <= rkt_pkg::ST_RELEASED;
            count_after <= alu_sum;
          end
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  // A result follows either an accepted transaction or a cycle of work
  a_done_cause: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy || start))
    else $error("result strobe without a transaction in flight");

  // The table is never written while idle
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !wr.en)
    else $error("table write while idle");

  // A hit always reports a live reference
  a_hit_nonzero: assert property (@(posedge clk) disable iff (rst)
    (done && status == rkt_pkg::ST_HIT) |-> (count_after != '0))
    else $error("hit reported with zero count");

  // Full is reported only when the scan found no free entry
  a_full_no_free: assert property (@(posedge clk) disable iff (rst)
    (done && status == rkt_pkg::ST_FULL) |-> !free_found)
    else $error("full reported although a free entry was seen");
`endif

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for refcounted_key_table: directed rows, table fill and drain,
// and random get/put traffic, scored against a local table mirror.
// Depends on rkt_pkg and refcounted_key_table.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rkt_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 80;
  localparam int RANDOM_ITEMS   = 1555;
  localparam int QUIET_TAIL     = 200;

  typedef struct packed {
    logic               op;
    logic [OWNER_W-1:0] owner;
    logic [KEY_W-1:0]   key;
    logic               present;
    logic [SLOT_W-1:0]  slot;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [REFS_W-1:0]   count;
  } outcome_t;

  typedef struct packed {
    request_t req;
    logic     typed;
    outcome_t want;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic opcode = OP_GET;
  logic [OWNER_W-1:0] owner_id = '0;
  logic [KEY_W-1:0] key = '0;
  logic slot_present = 1'b0;
  logic [SLOT_W-1:0] slot = '0;
  logic done;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0] result_slot;
  logic [REFS_W-1:0] count_after;

  // Typed expectation that travels with the directed row being presented
  logic typed_valid = 1'b0;
  outcome_t typed_outcome = '0;

  // Mirror of the entry table
  logic [OWNER_W-1:0] mirror_owner [TABLE_ENTRIES];
  logic [KEY_W-1:0]   mirror_key   [TABLE_ENTRIES];
  logic [REFS_W-1:0]  mirror_refs  [TABLE_ENTRIES];

  outcome_t pending_outcomes[$];
  int errors = 0;
  int accepted_count = 0;
  int idle_cycles = 0;
  int status_seen [8];
  logic idling_on = 1'b0;

  refcounted_key_table DUT (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .opcode(opcode),
    .owner_id(owner_id),
    .key(key),
    .slot_present(slot_present),
    .slot(slot),
    .done(done),
    .status(status),
    .result_slot(result_slot),
    .count_after(count_after)
  );

  always #5 clk = ~clk;

  // Apply one transaction to the mirror and return the outcome it must produce
  function automatic outcome_t predict_table(request_t r);
    outcome_t o;
    int hit;
    int free_slot;
    o = '0;
    hit = -1;
    free_slot = -1;
    if (r.op == OP_GET) begin
      if (r.owner == '0) begin
        o.status = ST_NULLOWNER;
        return o;
      end
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0 && mirror_owner[i] == r.owner && mirror_key[i] == r.key) hit = i;
        if (free_slot < 0 && mirror_refs[i] == '0) free_slot = i;
      end
      if (hit >= 0) begin
        if (mirror_refs[hit] != REFS_MAX) mirror_refs[hit] = mirror_refs[hit] + 1'b1;
        o = '{ST_HIT, hit[SLOT_W-1:0], mirror_refs[hit]};
      end else if (free_slot >= 0) begin
        mirror_owner[free_slot] = r.owner;
        mirror_key[free_slot] = r.key;
        mirror_refs[free_slot] = REFS_W'(1);
        o = '{ST_CLAIMED, free_slot[SLOT_W-1:0], 16'd1};
      end else begin
        o.status = ST_FULL;
      end
    end else begin
      if (!r.present) begin
        o.status = ST_NOOP;
      end else if (int'(r.slot) >= TABLE_ENTRIES) begin
        o = '{ST_NOOP, r.slot, 16'd0};
      end else if (mirror_refs[r.slot] == '0) begin
        o = '{ST_ZERO, r.slot, 16'd0};
      end else begin
        mirror_refs[r.slot] = mirror_refs[r.slot] - 1'b1;
        if (mirror_refs[r.slot] == '0) begin
          mirror_owner[r.slot] = '0;
          mirror_key[r.slot] = '0;
          o = '{ST_FREED, r.slot, 16'd0};
        end else begin
          o = '{ST_RELEASED, r.slot, mirror_refs[r.slot]};
        end
      end
    end
    return o;
  endfunction

  // Build a get; the put-only fields carry noise
  function automatic request_t mk_get(logic [OWNER_W-1:0] o, logic [KEY_W-1:0] k);
    return '{OP_GET, o, k, 1'($urandom_range(0, 1)), SLOT_W'($urandom_range(0, 63))};
  endfunction

  // Build a put; the get-only fields carry noise
  function automatic request_t mk_put(logic p, logic [SLOT_W-1:0] s);
    return '{OP_PUT, OWNER_W'($urandom_range(0, 255)), KEY_W'($urandom()), p, s};
  endfunction

  task automatic report_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  // Score accepted transactions and results at each rising edge
  always @(posedge clk) begin
    outcome_t want;
    outcome_t got;
    logic progress;
    progress = 1'b0;
    if (!rst) begin
      if (start && !busy) begin
        want = predict_table('{opcode, owner_id, key, slot_present, slot});
        if (typed_valid) want = typed_outcome;
        pending_outcomes.push_back(want);
        accepted_count++;
        progress = 1'b1;
      end
      if (done === 1'b1) begin
        got = '{status, result_slot, count_after};
        progress = 1'b1;
        if (pending_outcomes.size() == 0) begin
          $display("%0t: result with none expected: expected nothing, actual %0d/%0d/%0d",
                   $time, got.status, got.slot, got.count);
          errors++;
        end else begin
          want = pending_outcomes.pop_front();
          report_field("status", 32'(want.status), 32'(got.status));
          report_field("result_slot", 32'(want.slot), 32'(got.slot));
          report_field("count_after", 32'(want.count), 32'(got.count));
          if (!$isunknown(got.status)) status_seen[got.status]++;
        end
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
    end
  end

  // End the run if nothing moves for too long
  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("%0t: watchdog expired with %0d results outstanding", $time,
             pending_outcomes.size());
    $display("Regression FAIL");
    $finish;
  end

  // Present one transaction and hold it until the block takes it
  task automatic issue(request_t r, logic has_typed = 1'b0, outcome_t t = '0);
    opcode <= r.op;
    owner_id <= r.owner;
    key <= r.key;
    slot_present <= r.present;
    slot <= r.slot;
    typed_valid <= has_typed;
    typed_outcome <= t;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic rest(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic maybe_rest();
    if (idling_on && $urandom_range(0, 7) == 0) rest($urandom_range(1, 14));
  endtask

  initial begin
    row_t directed_rows[$];
    logic [OWNER_W-1:0] owner_pool [4];
    logic [KEY_W-1:0] key_pool [8];
    logic [OWNER_W-1:0] o;
    logic [KEY_W-1:0] k;
    logic [SLOT_W-1:0] s;
    int roll;
    int base;
    logic fill_heavy;
    logic found;

    owner_pool = '{8'h01, 8'h80, 8'hFF, 8'h5A};
    key_pool = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h1234_5678,
                 32'h0000_FFFF, 32'hFFFF_0000, 32'h5555_5555, 32'hAAAA_AAAA};
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      mirror_owner[i] = '0;
      mirror_key[i] = '0;
      mirror_refs[i] = '0;
    end
    foreach (status_seen[i]) status_seen[i] = 0;

    // Null owner, null slot and empty-entry puts, then claims, hits and releases
    directed_rows.push_back('{mk_get(8'h00, 32'h0), 1'b1, '{ST_NULLOWNER, 6'd0, 16'd0}});
    directed_rows.push_back('{mk_get(8'h00, 32'hFFFF_FFFF), 1'b1, '{ST_NULLOWNER, 6'd0, 16'd0}});
    directed_rows.push_back('{mk_put(1'b0, 6'd0), 1'b1, '{ST_NOOP, 6'd0, 16'd0}});
    directed_rows.push_back('{mk_put(1'b0, 6'd63), 1'b1, '{ST_NOOP, 6'd0, 16'd0}});
    directed_rows.push_back('{mk_put(1'b1, 6'd0), 1'b1, '{ST_ZERO, 6'd0, 16'd0}});
    directed_rows.push_back('{mk_put(1'b1, 6'd63), 1'b1, '{ST_ZERO, 6'd63, 16'd0}});
    directed_rows.push_back('{mk_get(8'h01, 32'h0), 1'b1, '{ST_CLAIMED, 6'd0, 16'd1}});
    directed_rows.push_back('{mk_get(8'hFF, 32'hFFFF_FFFF), 1'b1, '{ST_CLAIMED, 6'd1, 16'd1}});
    directed_rows.push_back('{mk_get(8'h01, 32'h0), 1'b1, '{ST_HIT, 6'd0, 16'd2}});
    directed_rows.push_back('{mk_get(8'h02, 32'h0), 1'b0, '0});
    directed_rows.push_back('{mk_get(8'h01, 32'h1), 1'b0, '0});
    directed_rows.push_back('{mk_get(8'hFF, 32'hFFFF_FFFF), 1'b0, '0});
    directed_rows.push_back('{mk_put(1'b1, 6'd0), 1'b0, '0});
    directed_rows.push_back('{mk_put(1'b1, 6'd0), 1'b0, '0});
    directed_rows.push_back('{mk_put(1'b1, 6'd0), 1'b0, '0});
    directed_rows.push_back('{mk_get(8'h05, 32'hAAAA_5555), 1'b0, '0});
    directed_rows.push_back('{mk_get(8'h01, 32'h0), 1'b0, '0});
    directed_rows.push_back('{mk_put(1'b1, 6'd2), 1'b0, '0});
    directed_rows.push_back('{mk_get(8'hAA, 32'h5555_5555), 1'b0, '0});
    directed_rows.push_back('{mk_get(8'h80, 32'h8000_0000), 1'b0, '0});
    directed_rows.push_back('{mk_put(1'b1, 6'd1), 1'b0, '0});
    directed_rows.push_back('{mk_put(1'b1, 6'd1), 1'b0, '0});

    // Hold reset, then release it
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    idling_on = 1'b1;

    foreach (directed_rows[i]) begin
      issue(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].want);
      maybe_rest();
    end

    // Fill every free entry and overflow the table, hit while full, then drain
    for (int i = 0; i < TABLE_ENTRIES + 2; i++) begin
      issue(mk_get(8'h3C, 32'h0001_0000 + i));
      maybe_rest();
    end
    issue(mk_get(8'h05, 32'hAAAA_5555));
    for (int i = 0; i < TABLE_ENTRIES; i++)
      repeat (4) issue(mk_put(1'b1, SLOT_W'(i)));

    // Random traffic: epochs alternate between filling and draining the table
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      idling_on = (i < RANDOM_ITEMS - QUIET_TAIL) && ((i / 100) % 2 == 0);
      fill_heavy = ((i / 150) % 2 == 0);
      roll = $urandom_range(0, 99);
      if (roll < (fill_heavy ? 75 : 35)) begin
        roll = $urandom_range(0, 99);
        if (roll < 4) o = '0;
        else if (roll < 12) o = OWNER_W'($urandom_range(0, 255));
        else o = owner_pool[$urandom_range(0, 3)];
        if ($urandom_range(0, 99) < (fill_heavy ? 50 : 15)) k = $urandom();
        else k = key_pool[$urandom_range(0, 7)];
        issue(mk_get(o, k));
      end else begin
        roll = $urandom_range(0, 99);
        if (roll < 5) begin
          issue(mk_put(1'b0, SLOT_W'($urandom_range(0, 63))));
        end else if (roll < 15) begin
          issue(mk_put(1'b1, SLOT_W'($urandom_range(0, 63))));
        end else begin
          // Pick an entry in use; the mirror may lag by one transaction, which is harmless
          base = $urandom_range(0, TABLE_ENTRIES - 1);
          found = 1'b0;
          s = SLOT_W'(base);
          for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (!found && mirror_refs[(base + j) % TABLE_ENTRIES] != '0) begin
              found = 1'b1;
              s = SLOT_W'((base + j) % TABLE_ENTRIES);
            end
          end
          issue(mk_put(1'b1, s));
        end
      end
      maybe_rest();
    end
    start <= 1'b0;

    // Wait for the last results, then give the block time to show any stray one
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_outcomes.size() != 0) begin
      $display("%0t: results missing: expected %0d more, actual 0", $time,
               pending_outcomes.size());
      errors++;
    end

    $display("Covered %0d transactions: %0d hit, %0d claimed, %0d full, %0d released, %0d freed",
             accepted_count, status_seen[ST_HIT], status_seen[ST_CLAIMED],
             status_seen[ST_FULL], status_seen[ST_RELEASED], status_seen[ST_FREED]);
    $display("  %0d already-zero puts, %0d null-owner gets, %0d no-op puts, %0d errors",
             status_seen[ST_ZERO], status_seen[ST_NULLOWNER], status_seen[ST_NOOP], errors);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ refcounted_key_table.f @@
rtl/core/rkt_pkg.sv
rtl/core/rkt_table.sv
rtl/core/refcounted_key_table.sv
tb/testbench.sv
